### src/mbss_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner package
// Shared types, register indexes and default sizes for the scanner.
// ----------------------------------------------------------------------------
package mbss_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAX_PATTERN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int SIG_BYTES   = 16;
	localparam int LEN_FIELD_W = 5;
	localparam int OFFSET_W    = 32;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 2'd3;

	// One input request.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_start;
		logic       scan_start;
	} in_t;

	// One result.
	typedef struct packed {
		logic                match;
		logic                first_match_res;
		logic [OFFSET_W-1:0] match_offset;
	} out_t;

	// Configuration as seen by the match logic.
	typedef struct packed {
		logic [63:0]            pattern_high_bytes;
		logic [63:0]            pattern_low_bytes;
		logic [SIG_BYTES-1:0]   wildcard_bits;
		logic [LEN_FIELD_W-1:0] pattern_length;
	} cfg_t;

endpackage

### src/mbss_cfg.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner configuration registers
// Holds the signature, the wildcard mask and the signature length.
// ----------------------------------------------------------------------------
module mbss_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [mbss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mbss_pkg::cfg_t                   cfg
);
	import mbss_pkg::*;

	cfg_t cfg_q;

	// Register writes; the length resets to one byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low_bytes  <= '0;
			cfg_q.pattern_high_bytes <= '0;
			cfg_q.wildcard_bits      <= '0;
			cfg_q.pattern_length     <= LEN_FIELD_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  cfg_q.pattern_low_bytes  <= cfg_data;
				REG_PATTERN_HIGH: cfg_q.pattern_high_bytes <= cfg_data;
				REG_WILDCARD:     cfg_q.wildcard_bits      <= cfg_data[SIG_BYTES-1:0];
				REG_LENGTH:       cfg_q.pattern_length     <= cfg_data[LEN_FIELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/mbss_match.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner match stage
// Keeps the byte window, fill count, scan position and found flag, and
// compares the updated window against the signature in one pass.
// ----------------------------------------------------------------------------
module mbss_match #(
	parameter int MAX_PATTERN   = mbss_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = mbss_pkg::POSITION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  mbss_pkg::in_t  item,
	input  mbss_pkg::cfg_t cfg,
	output mbss_pkg::out_t result
);
	import mbss_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]               window_q [MAX_PATTERN];
	logic [7:0]               window_new [MAX_PATTERN];
	logic [LEN_W-1:0]         fill_q;
	logic [LEN_W-1:0]         fill_eff;
	logic [LEN_W-1:0]         fill_new;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] here;
	logic [POSITION_BITS-1:0] offset;
	logic [63:0]              offset_ext;
	logic                     found_q;
	logic                     found_eff;
	logic [LEN_W-1:0]         len_eff;
	logic [LEN_W-1:0]         len_m1;
	logic [8*SIG_BYTES-1:0]   sig;
	logic [MAX_PATTERN-1:0]   byte_ok;
	logic                     hit;

	assign sig = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

	// Clamp the programmed length to the range one to MAX_PATTERN.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_FIELD_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(cfg.pattern_length);
		end
		len_m1 = len_eff - LEN_W'(1);
	end

	// Apply the start flags, then shift the new byte into the window.
	always_comb begin
		fill_eff  = item.region_start ? '0 : fill_q;
		fill_new  = (fill_eff < LEN_W'(MAX_PATTERN)) ? fill_eff + LEN_W'(1) : fill_eff;
		found_eff = item.scan_start ? 1'b0 : found_q;
		here      = item.scan_start ? '0 : pos_q;
		window_new[0] = item.data_byte;
		for (int a = 1; a < MAX_PATTERN; a++) begin
			window_new[a] = window_q[a-1];
		end
	end

	// Signature byte i lines up with the window byte of age length-1-i.
	always_comb begin
		logic [LEN_W-1:0] age;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			age = len_m1 - LEN_W'(i);
			byte_ok[i] = (LEN_W'(i) >= len_eff) || cfg.wildcard_bits[i] ||
				(window_new[age[IDX_W-1:0]] == sig[8*i +: 8]);
		end
	end

	assign hit        = (fill_new >= len_eff) && (&byte_ok);
	assign offset     = here - POSITION_BITS'(len_m1);
	assign offset_ext = 64'(offset);

	// Result fields; the offset and first flag read as zero without a match.
	always_comb begin
		result.match           = hit;
		result.first_match_res = hit && !found_eff;
		result.match_offset    = hit ? offset_ext[OFFSET_W-1:0] : '0;
	end

	// Control state advances with each request that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			fill_q  <= fill_new;
			pos_q   <= here + POSITION_BITS'(1);
			found_q <= found_eff || hit;
		end
	end

	// Window bytes are only read once the fill count covers them.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < MAX_PATTERN; a++) begin
				window_q[a] <= window_new[a];
			end
		end
	end

endmodule

### src/masked_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner
// Searches a byte stream for a wildcard signature and reports each match.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle while out_stall is low and gives one
// result per byte; each byte passes through the input register and then the
// result register. Every window position is compared side by side in the single
// match stage, so the rate does not depend on the signature length. A stalled
// output holds the result register, and the input register keeps taking a byte
// until it too is full. Configuration must be written only while no request is in
// flight.
module masked_byte_signature_scanner #(
	parameter int MAX_PATTERN   = mbss_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = mbss_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mbss_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mbss_pkg::out_t                   out_data,
	input  logic                             cfg_write,
	input  logic [mbss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbss_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	out_t result;
	out_t result_q;
	logic out_valid_q;
	logic advance;
	logic accept;

	mbss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbss_match #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// A request moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

endmodule
